// ===== rtl/sflpa_pkg.sv =====
// Shared constants, codes and control structs of the sorted free-list pool allocator.
`timescale 1ns / 1ps

package sflpa_pkg;

	// Field and port widths
	localparam int OFF_W     = 24;
	localparam int BYTES_W   = 16;
	localparam int COUNT_W   = 9;
	localparam int INDEX_W   = 8;
	localparam int STATUS_W  = 2;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int WIDE_W    = 48;
	localparam int DIV_CNT_W = 5;

	// Defaults
	localparam int DEF_POOL_DEPTH = 256;
	localparam logic [BYTES_W-1:0] DEF_BLOCK_BYTES = 16'd64;
	localparam logic [COUNT_W-1:0] DEF_BLOCK_COUNT = 9'd256;

	localparam logic [OFF_W-1:0] FREE_BYTES_MAX = 24'hFF_FFFF;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DUP   = 2'd3;

	// Register index codes (taken from paddr bit 2)
	localparam logic REG_BYTES = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// Multiplier operand select
	localparam logic [1:0] MUL_HEAD  = 2'd0;
	localparam logic [1:0] MUL_COUNT = 2'd1;
	localparam logic [1:0] MUL_LIMIT = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic                sweep_clr;
		logic                sweep_en;
		logic                load;
		logic [1:0]          mul_sel;
		logic                set_err;
		logic [STATUS_W-1:0] err_code;
		logic                al_pop;
		logic                div_start;
		logic                walk_init;
		logic                walk_step;
		logic                walk_end;
		logic                wr_idx;
		logic                wr_prev;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic sweep_last;
		logic head_empty;
		logic range_err;
		logic div_done;
		logic walk_more;
		logic walk_dup;
	} dp_stat_t;

endpackage

// ===== rtl/sorted_free_list_pool_allocator.sv =====
// Top level of the sorted free-list pool allocator.
// Allocate: read the list head, pop it and post the result; one request at a time.
// Free: range check, divide, walk of the address-ordered list and two link writes; an
// out-of-range free or one that finds its block already free skips the rest.
// Reset and every config write start a clearing sweep of one cycle per block in use
// (block_count clamped to 1..POOL_DEPTH) with busy high; results cannot be stalled.
`timescale 1ns / 1ps

module sorted_free_list_pool_allocator #(
	parameter int POOL_DEPTH = sflpa_pkg::DEF_POOL_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sflpa_pkg::ADDR_W-1:0]    paddr,
	input  logic [sflpa_pkg::DATA_W-1:0]    pwdata,
	output logic [sflpa_pkg::DATA_W-1:0]    prdata,
	output logic                            pready,
	input  logic                            start,
	output logic                            busy,
	input  logic                            op,
	input  logic [sflpa_pkg::OFF_W-1:0]     block_offset,
	output logic                            done,
	output logic [sflpa_pkg::STATUS_W-1:0]  status,
	output logic [sflpa_pkg::INDEX_W-1:0]   block_index,
	output logic [sflpa_pkg::OFF_W-1:0]     granted_offset,
	output logic [sflpa_pkg::COUNT_W-1:0]   free_blocks,
	output logic [sflpa_pkg::OFF_W-1:0]     free_bytes
);

	logic [sflpa_pkg::BYTES_W-1:0] cfg_bytes;
	logic [sflpa_pkg::COUNT_W-1:0] cfg_count;
	logic                          cfg_wr;
	sflpa_pkg::dp_cmd_t            cmd;
	sflpa_pkg::dp_stat_t           stat;

	// Configuration registers
	sflpa_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.block_bytes (cfg_bytes),
		.block_count (cfg_count),
		.cfg_wr      (cfg_wr)
	);

	// Controller
	sflpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.cfg_wr (cfg_wr),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath
	sflpa_dp #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.block_bytes    (cfg_bytes),
		.block_count    (cfg_count),
		.block_offset   (block_offset),
		.status         (status),
		.block_index    (block_index),
		.granted_offset (granted_offset),
		.free_blocks    (free_blocks),
		.free_bytes     (free_bytes)
	);

endmodule

// ===== rtl/sflpa_regs.sv =====
// APB configuration registers: block size and block count.
`timescale 1ns / 1ps

module sflpa_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sflpa_pkg::ADDR_W-1:0]     paddr,
	input  logic [sflpa_pkg::DATA_W-1:0]     pwdata,
	output logic [sflpa_pkg::DATA_W-1:0]     prdata,
	output logic                             pready,
	output logic [sflpa_pkg::BYTES_W-1:0]    block_bytes,
	output logic [sflpa_pkg::COUNT_W-1:0]    block_count,
	output logic                             cfg_wr
);

	logic [sflpa_pkg::BYTES_W-1:0] bytes_q;
	logic [sflpa_pkg::COUNT_W-1:0] count_q;
	logic                          reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[sflpa_pkg::ADDR_W-1];
	assign cfg_wr  = psel & penable & pwrite & pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= sflpa_pkg::DEF_BLOCK_BYTES;
			count_q <= sflpa_pkg::DEF_BLOCK_COUNT;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				sflpa_pkg::REG_BYTES: bytes_q <= pwdata[sflpa_pkg::BYTES_W-1:0];
				sflpa_pkg::REG_COUNT: count_q <= pwdata[sflpa_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_sel)
			sflpa_pkg::REG_BYTES: prdata = sflpa_pkg::DATA_W'(bytes_q);
			sflpa_pkg::REG_COUNT: prdata = sflpa_pkg::DATA_W'(count_q);
			default:              prdata = '0;
		endcase
	end

	assign block_bytes = bytes_q;
	assign block_count = count_q;

endmodule

// ===== rtl/sflpa_div.sv =====
// Restoring divider: one quotient bit per cycle, offset by block size.
`timescale 1ns / 1ps

module sflpa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sflpa_pkg::OFF_W-1:0]   dividend,
	input  logic [sflpa_pkg::BYTES_W-1:0] divisor,
	output logic                          done,
	output logic [sflpa_pkg::OFF_W-1:0]   quotient
);

	localparam logic [sflpa_pkg::DIV_CNT_W-1:0] LAST_STEP =
		sflpa_pkg::DIV_CNT_W'(sflpa_pkg::OFF_W - 1);

	logic                            run_q;
	logic [sflpa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [sflpa_pkg::BYTES_W-1:0]   rem_q;
	logic [sflpa_pkg::BYTES_W-1:0]   div_q;
	logic [sflpa_pkg::OFF_W-1:0]     quo_q;
	logic [sflpa_pkg::BYTES_W:0]     trial;
	logic [sflpa_pkg::BYTES_W:0]     diff;
	logic                            ge;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[sflpa_pkg::OFF_W-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + sflpa_pkg::DIV_CNT_W'(1);
			if (cnt_q == LAST_STEP) begin
				run_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[sflpa_pkg::BYTES_W-1:0] : trial[sflpa_pkg::BYTES_W-1:0];
			quo_q <= {quo_q[sflpa_pkg::OFF_W-2:0], ge};
		end
	end

	assign done     = run_q && (cnt_q == LAST_STEP);
	assign quotient = quo_q;

endmodule

// ===== rtl/sflpa_dp.sv =====
// Datapath: link memory, list head, free count, multiplier, walk and result registers.
`timescale 1ns / 1ps

module sflpa_dp #(
	parameter int POOL_DEPTH = sflpa_pkg::DEF_POOL_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sflpa_pkg::dp_cmd_t             cmd,
	output sflpa_pkg::dp_stat_t            stat,
	input  logic [sflpa_pkg::BYTES_W-1:0]  block_bytes,
	input  logic [sflpa_pkg::COUNT_W-1:0]  block_count,
	input  logic [sflpa_pkg::OFF_W-1:0]    block_offset,
	output logic [sflpa_pkg::STATUS_W-1:0] status,
	output logic [sflpa_pkg::INDEX_W-1:0]  block_index,
	output logic [sflpa_pkg::OFF_W-1:0]    granted_offset,
	output logic [sflpa_pkg::COUNT_W-1:0]  free_blocks,
	output logic [sflpa_pkg::OFF_W-1:0]    free_bytes
);

	localparam int IW = $clog2(POOL_DEPTH);
	localparam int LW = IW + 1;
	localparam int PW = LW + sflpa_pkg::BYTES_W;
	localparam int CW = (LW > sflpa_pkg::COUNT_W) ? LW : sflpa_pkg::COUNT_W;
	localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

	// Link memory
	logic [LW-1:0] mem [POOL_DEPTH];
	logic [LW-1:0] rdata_q;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [LW-1:0] mem_wdata;
	logic [IW-1:0] mem_raddr;

	// Control state
	logic [LW-1:0] head_q;
	logic [LW-1:0] count_q;
	logic [IW-1:0] sweep_q;

	// Working registers
	logic [sflpa_pkg::OFF_W-1:0]    off_q;
	logic [PW-1:0]                  prod_q;
	logic                           first_q;
	logic [LW-1:0]                  prev_q;
	logic [LW-1:0]                  cur_q;
	logic [sflpa_pkg::STATUS_W-1:0] status_q;
	logic [sflpa_pkg::INDEX_W-1:0]  idx_q;
	logic [sflpa_pkg::OFF_W-1:0]    goff_q;

	logic [sflpa_pkg::BYTES_W-1:0] bytes_eff;
	logic [CW-1:0]                 count_x;
	logic [LW-1:0]                 n_eff;
	logic [LW-1:0]                 sweep_nxt;
	logic [LW-1:0]                 cur;
	logic [LW-1:0]                 idx_l;
	logic [LW-1:0]                 mul_a;
	logic [sflpa_pkg::WIDE_W-1:0]  prod_w;
	logic                          div_done;
	logic [sflpa_pkg::OFF_W-1:0]   quotient;

	// Effective block size and count
	always_comb begin
		bytes_eff = (block_bytes == '0) ? sflpa_pkg::BYTES_W'(1) : block_bytes;
		count_x   = CW'(block_count);
		if (count_x == '0) begin
			n_eff = LW'(1);
		end else if (count_x > CW'(POOL_DEPTH)) begin
			n_eff = NIL;
		end else begin
			n_eff = LW'(count_x);
		end
	end

	// Offset to block index
	sflpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (off_q),
		.divisor  (bytes_eff),
		.done     (div_done),
		.quotient (quotient)
	);

	assign idx_l     = LW'(quotient);
	assign sweep_nxt = {1'b0, sweep_q} + LW'(1);
	assign cur       = first_q ? head_q : rdata_q;

	// Status to controller
	always_comb begin
		stat.sweep_last = sweep_nxt >= n_eff;
		stat.head_empty = head_q >= n_eff;
		stat.range_err  = sflpa_pkg::WIDE_W'(off_q) >= sflpa_pkg::WIDE_W'(prod_q);
		stat.div_done   = div_done;
		stat.walk_more  = (cur < n_eff) && (cur < idx_l);
		stat.walk_dup   = cur == idx_l;
	end

	// Memory write port select
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		priority if (cmd.sweep_en) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_q;
			mem_wdata = (sweep_nxt < n_eff) ? sweep_nxt : NIL;
		end else if (cmd.wr_idx) begin
			mem_we    = 1'b1;
			mem_waddr = IW'(idx_l);
			mem_wdata = (cur_q < n_eff) ? cur_q : NIL;
		end else if (cmd.wr_prev && (prev_q < n_eff)) begin
			mem_we    = 1'b1;
			mem_waddr = IW'(prev_q);
			mem_wdata = idx_l;
		end else begin
			mem_we    = 1'b0;
		end
	end

	assign mem_raddr = cmd.walk_step ? IW'(cur) : IW'(head_q);

	// Link memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Clearing sweep position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_clr) begin
			sweep_q <= '0;
		end else if (cmd.sweep_en) begin
			sweep_q <= sweep_q + IW'(1);
		end
	end

	// List head and free count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.sweep_en) begin
			head_q  <= '0;
			count_q <= n_eff;
		end else if (cmd.al_pop) begin
			head_q <= rdata_q;
			if (count_q != '0) begin
				count_q <= count_q - LW'(1);
			end
		end else if (cmd.wr_prev) begin
			if (prev_q >= n_eff) begin
				head_q <= idx_l;
			end
			if (count_q < n_eff) begin
				count_q <= count_q + LW'(1);
			end
		end
	end

	// Shared multiplier operand
	always_comb begin
		unique case (cmd.mul_sel)
			sflpa_pkg::MUL_HEAD:  mul_a = head_q;
			sflpa_pkg::MUL_COUNT: mul_a = count_q;
			sflpa_pkg::MUL_LIMIT: mul_a = n_eff;
			default:              mul_a = count_q;
		endcase
	end

	// Request capture, product, walk and result registers
	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(bytes_eff);
		if (cmd.load) begin
			off_q <= block_offset;
		end
		if (cmd.walk_init) begin
			first_q <= 1'b1;
			prev_q  <= NIL;
		end else if (cmd.walk_step) begin
			first_q <= 1'b0;
			prev_q  <= cur;
		end
		if (cmd.walk_end) begin
			cur_q <= cur;
		end
		if (cmd.set_err) begin
			status_q <= cmd.err_code;
			idx_q    <= '0;
			goff_q   <= '0;
		end else if (cmd.al_pop) begin
			status_q <= sflpa_pkg::ST_OK;
			idx_q    <= sflpa_pkg::INDEX_W'(head_q);
			goff_q   <= sflpa_pkg::OFF_W'(prod_q);
		end else if (cmd.wr_prev) begin
			status_q <= sflpa_pkg::ST_OK;
			idx_q    <= sflpa_pkg::INDEX_W'(idx_l);
			goff_q   <= '0;
		end
	end

	// Result fields
	assign prod_w         = sflpa_pkg::WIDE_W'(prod_q);
	assign status         = status_q;
	assign block_index    = idx_q;
	assign granted_offset = goff_q;
	assign free_blocks    = sflpa_pkg::COUNT_W'(count_q);
	assign free_bytes     = (prod_w > sflpa_pkg::WIDE_W'(sflpa_pkg::FREE_BYTES_MAX)) ?
		sflpa_pkg::FREE_BYTES_MAX : sflpa_pkg::OFF_W'(prod_q);

endmodule

// ===== rtl/sflpa_ctrl.sv =====
// Controller state machine: sequences clearing sweep, allocate and free requests.
`timescale 1ns / 1ps

module sflpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                op,
	input  logic                cfg_wr,
	input  sflpa_pkg::dp_stat_t stat,
	output sflpa_pkg::dp_cmd_t  cmd,
	output logic                busy,
	output logic                done
);

	localparam logic [3:0] S_INIT    = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_AL_RD   = 4'd2;
	localparam logic [3:0] S_AL_UPD  = 4'd3;
	localparam logic [3:0] S_FR_MUL  = 4'd4;
	localparam logic [3:0] S_FR_CHK  = 4'd5;
	localparam logic [3:0] S_FR_DIV  = 4'd6;
	localparam logic [3:0] S_FR_WALK = 4'd7;
	localparam logic [3:0] S_FR_W1   = 4'd8;
	localparam logic [3:0] S_FR_W2   = 4'd9;
	localparam logic [3:0] S_FB      = 4'd10;
	localparam logic [3:0] S_OUT     = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	// State register; a config write restarts the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else if (cfg_wr) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = sflpa_pkg::MUL_COUNT;
		cmd.sweep_clr = cfg_wr;
		state_nxt     = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep_en = !cfg_wr;
				if (stat.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = op ? S_FR_MUL : S_AL_RD;
				end
			end
			S_AL_RD: begin
				if (stat.head_empty) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = sflpa_pkg::ST_EMPTY;
					state_nxt    = S_FB;
				end else begin
					cmd.mul_sel = sflpa_pkg::MUL_HEAD;
					state_nxt   = S_AL_UPD;
				end
			end
			S_AL_UPD: begin
				cmd.al_pop = 1'b1;
				state_nxt  = S_FB;
			end
			S_FR_MUL: begin
				cmd.mul_sel = sflpa_pkg::MUL_LIMIT;
				state_nxt   = S_FR_CHK;
			end
			S_FR_CHK: begin
				if (stat.range_err) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = sflpa_pkg::ST_RANGE;
					state_nxt    = S_FB;
				end else begin
					cmd.div_start = 1'b1;
					cmd.walk_init = 1'b1;
					state_nxt     = S_FR_DIV;
				end
			end
			S_FR_DIV: begin
				if (stat.div_done) begin
					state_nxt = S_FR_WALK;
				end
			end
			S_FR_WALK: begin
				if (stat.walk_more) begin
					cmd.walk_step = 1'b1;
				end else if (stat.walk_dup) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = sflpa_pkg::ST_DUP;
					state_nxt    = S_FB;
				end else begin
					cmd.walk_end = 1'b1;
					state_nxt    = S_FR_W1;
				end
			end
			S_FR_W1: begin
				cmd.wr_idx = 1'b1;
				state_nxt  = S_FR_W2;
			end
			S_FR_W2: begin
				cmd.wr_prev = 1'b1;
				state_nxt   = S_FB;
			end
			S_FB: begin
				cmd.mul_sel = sflpa_pkg::MUL_COUNT;
				state_nxt   = S_OUT;
			end
			S_OUT: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_INIT;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;

endmodule

// ===== tb/sflpa_tb_pkg.sv =====
// Request codes and register address layout shared by the allocator testbench files.
`timescale 1ns / 1ps

package sflpa_tb_pkg;

	// Request kinds on the op port
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Registers sit 4 bytes apart, so paddr bit 2 selects the register
	localparam int REG_SEL_BIT = 2;

endpackage

// ===== tb/sflpa_checker.sv =====
// Reply checker: tracks the free list, predicts each reply and compares it with the block.
`timescale 1ns / 1ps

module sflpa_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sflpa_pkg::ADDR_W-1:0]   paddr,
	input  logic [sflpa_pkg::DATA_W-1:0]   pwdata,
	input  logic                           pready,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           op,
	input  logic [sflpa_pkg::OFF_W-1:0]    block_offset,
	input  logic                           done,
	input  logic [sflpa_pkg::STATUS_W-1:0] status,
	input  logic [sflpa_pkg::INDEX_W-1:0]  block_index,
	input  logic [sflpa_pkg::OFF_W-1:0]    granted_offset,
	input  logic [sflpa_pkg::COUNT_W-1:0]  free_blocks,
	input  logic [sflpa_pkg::OFF_W-1:0]    free_bytes,
	output int                             fail_count,
	output int                             pending,
	output int                             replies_checked,
	output int                             empty_hits,
	output int                             range_hits,
	output int                             dup_hits
);
	import sflpa_pkg::*;
	import sflpa_tb_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  block_index;
		logic [OFF_W-1:0]    granted_offset;
		logic [COUNT_W-1:0]  free_blocks;
		logic [OFF_W-1:0]    free_bytes;
	} pool_reply_t;

	// End-of-list marker in the link table
	localparam int LINK_END = DEF_POOL_DEPTH;

	logic [COUNT_W-1:0] link_next [DEF_POOL_DEPTH];
	logic [COUNT_W-1:0] head;
	logic [COUNT_W-1:0] free_cnt;
	logic [BYTES_W-1:0] cfg_bytes;
	logic [COUNT_W-1:0] cfg_count;
	pool_reply_t        expected_replies [$];

	initial begin
		fail_count = 0;
		replies_checked = 0;
		empty_hits = 0;
		range_hits = 0;
		dup_hits = 0;
	end

	// A zero block size behaves as one byte
	function automatic int unsigned eff_bytes();
		return (cfg_bytes == 0) ? 1 : cfg_bytes;
	endfunction

	// Block count clamps to 1..pool depth
	function automatic int unsigned eff_count();
		if (cfg_count == 0) return 1;
		if (cfg_count > DEF_POOL_DEPTH) return DEF_POOL_DEPTH;
		return cfg_count;
	endfunction

	// All blocks free, linked in address order
	function automatic void rebuild_pool();
		int unsigned n;
		n = eff_count();
		for (int i = 0; i < DEF_POOL_DEPTH; i++)
			link_next[i] = COUNT_W'((i + 1 < n) ? i + 1 : LINK_END);
		head = '0;
		free_cnt = COUNT_W'(n);
	endfunction

	// Applies one request to the tracked list and returns the reply it must produce
	function automatic pool_reply_t apply_request(logic kind, logic [OFF_W-1:0] off);
		int unsigned bsz, n, idx, prev, cur, steps, room;
		pool_reply_t r;
		bsz = eff_bytes();
		n = eff_count();
		r = '0;
		r.status = ST_OK;
		if (kind == OP_ALLOC) begin
			// pop the head, which is always the lowest free block
			if (head >= n) begin
				r.status = ST_EMPTY;
			end else begin
				r.block_index = INDEX_W'(head);
				r.granted_offset = OFF_W'(head * bsz);
				head = link_next[head];
				if (free_cnt > 0) free_cnt--;
			end
		end else if (off >= n * bsz) begin
			r.status = ST_RANGE;
		end else begin
			// walk to the insertion point; landing on the block means it is already free
			idx = off / bsz;
			prev = LINK_END;
			cur = head;
			steps = 0;
			while (cur < n && cur < idx && steps < DEF_POOL_DEPTH) begin
				prev = cur;
				cur = link_next[cur];
				steps++;
			end
			if (cur == idx) begin
				r.status = ST_DUP;
			end else begin
				link_next[idx] = COUNT_W'((cur < n) ? cur : LINK_END);
				if (prev < n) link_next[prev] = COUNT_W'(idx);
				else head = COUNT_W'(idx);
				if (free_cnt < n) free_cnt++;
				r.block_index = INDEX_W'(idx);
			end
		end
		room = free_cnt * bsz;
		r.free_blocks = free_cnt;
		r.free_bytes = (room > FREE_BYTES_MAX) ? FREE_BYTES_MAX : OFF_W'(room);
		return r;
	endfunction

	function automatic void report_failure(string msg);
		if (fail_count < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		pool_reply_t want;
		string diff;
		if (!arst_n) begin
			cfg_bytes = DEF_BLOCK_BYTES;
			cfg_count = DEF_BLOCK_COUNT;
			rebuild_pool();
			expected_replies.delete();
			pending = 0;
		end else begin
			// Reply on the result ports
			if (done) begin
				if (expected_replies.size() == 0) begin
					report_failure($sformatf("reply with none expected: status %0d index %0d",
						status, block_index));
				end else begin
					want = expected_replies.pop_front();
					replies_checked++;
					case (want.status)
						ST_EMPTY: empty_hits++;
						ST_RANGE: range_hits++;
						ST_DUP:   dup_hits++;
						default:  ;
					endcase
					diff = "";
					if (status !== want.status)
						diff = {diff, $sformatf(" status exp %0d got %0d", want.status, status)};
					if (block_index !== want.block_index)
						diff = {diff, $sformatf(" index exp %0d got %0d",
							want.block_index, block_index)};
					if (granted_offset !== want.granted_offset)
						diff = {diff, $sformatf(" offset exp %0h got %0h",
							want.granted_offset, granted_offset)};
					if (free_blocks !== want.free_blocks)
						diff = {diff, $sformatf(" free_blocks exp %0d got %0d",
							want.free_blocks, free_blocks)};
					if (free_bytes !== want.free_bytes)
						diff = {diff, $sformatf(" free_bytes exp %0d got %0d",
							want.free_bytes, free_bytes)};
					if (diff != "") report_failure($sformatf("reply %0d:%s", replies_checked, diff));
				end
			end
			// Register write rebuilds the list
			if (psel && penable && pwrite && pready) begin
				if (paddr[REG_SEL_BIT] == REG_BYTES) cfg_bytes = pwdata[BYTES_W-1:0];
				else cfg_count = pwdata[COUNT_W-1:0];
				rebuild_pool();
			end
			// Accepted request
			if (start && !busy) expected_replies.push_back(apply_request(op, block_offset));
			pending = expected_replies.size();
		end
	end

endmodule

// ===== tb/sorted_free_list_pool_allocator_tb.sv =====
// Testbench top: drives requests and register writes into the pool allocator and reports the verdict.
`timescale 1ns / 1ps

module sorted_free_list_pool_allocator_tb;
	import sflpa_pkg::*;
	import sflpa_tb_pkg::*;

	// Sender idle modes
	localparam int IDLE_NONE  = 0;
	localparam int IDLE_HEAVY = 1;
	localparam int IDLE_LIGHT = 2;

	localparam int PHASES         = 8;
	localparam int PHASE_REQUESTS = 204;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic                op;
	logic [OFF_W-1:0]    block_offset;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  block_index;
	logic [OFF_W-1:0]    granted_offset;
	logic [COUNT_W-1:0]  free_blocks;
	logic [OFF_W-1:0]    free_bytes;

	int fail_count, pending, replies_checked, empty_hits, range_hits, dup_hits;
	int idle_mode;
	int config_writes;
	int unsigned pool_b, pool_n;
	bit held [DEF_POOL_DEPTH];

	sorted_free_list_pool_allocator DUT (.*);

	sflpa_checker reply_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int gap, pct;
		gap = 0;
		pct = (idle_mode == IDLE_HEAVY) ? 83 : (idle_mode == IDLE_LIGHT) ? 10 : 0;
		while (gap < 60 && $urandom_range(99) < pct) gap++;
		return gap;
	endfunction

	// One request; entered and left at a falling edge without touching start on exit
	task automatic issue(logic kind, logic [OFF_W-1:0] off);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			// idle cycles count from the point the block could take a request
			start <= 1'b0;
			while (busy) @(negedge clk);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		op <= kind;
		block_offset <= off;
		do @(posedge clk); while (busy);
		@(negedge clk);
		// rough view of taken blocks for aiming frees; allocate takes the lowest free one
		if (kind == OP_ALLOC) begin
			for (int i = 0; i < pool_n; i++) begin
				if (!held[i]) begin
					held[i] = 1'b1;
					break;
				end
			end
		end else if (off < pool_n * pool_b) begin
			held[off / pool_b] = 1'b0;
		end
	endtask

	// Stop sending and wait for every outstanding reply
	task automatic drain();
		start <= 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic reg_write(logic sel, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(sel) << REG_SEL_BIT;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		config_writes++;
		// let the clearing sweep start, then wait it out
		repeat (2) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	// Reconfigure the pool; upper data bits carry junk to exercise masking
	task automatic set_pool(logic [BYTES_W-1:0] bsz, logic [COUNT_W-1:0] cnt);
		drain();
		reg_write(REG_BYTES, {16'($urandom), bsz});
		reg_write(REG_COUNT, {23'($urandom), cnt});
		pool_b = (bsz == 0) ? 1 : bsz;
		pool_n = (cnt == 0) ? 1 : (cnt > DEF_POOL_DEPTH) ? DEF_POOL_DEPTH : cnt;
		foreach (held[i]) held[i] = 1'b0;
	endtask

	// alloc_pct percent allocations; frees mostly at random spots in taken blocks, plus dups and junk
	task automatic random_request(int alloc_pct);
		int unsigned idx, span, roll;
		span = pool_n * pool_b;
		roll = $urandom_range(99);
		if ($urandom_range(99) < alloc_pct) begin
			issue(OP_ALLOC, OFF_W'($urandom));
		end else if (roll < 70) begin
			idx = $urandom_range(pool_n - 1);
			for (int t = 0; t < 16 && !held[idx]; t++) idx = $urandom_range(pool_n - 1);
			issue(OP_FREE, OFF_W'(idx * pool_b + $urandom_range(pool_b - 1)));
		end else if (roll < 82) begin
			issue(OP_FREE, OFF_W'($urandom_range(span - 1)));
		end else if (roll < 92) begin
			issue(OP_FREE, OFF_W'($urandom_range(FREE_BYTES_MAX, span)));
		end else begin
			issue(OP_FREE, OFF_W'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [BYTES_W-1:0] phase_bytes [PHASES];
		logic [COUNT_W-1:0] phase_count [PHASES];
		int wave_pct;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		op = OP_ALLOC;
		block_offset = '0;
		idle_mode = IDLE_NONE;
		config_writes = 0;
		pool_b = DEF_BLOCK_BYTES;
		pool_n = DEF_BLOCK_COUNT;
		wave_pct = 50;
		foreach (held[i]) held[i] = 1'b0;
		phase_bytes = '{16'd64, 16'd1, 16'hFFFF, 16'd0, 16'd100, 16'd7, 16'd0, 16'd3};
		phase_count = '{9'd256, 9'd1, 9'd256, 9'd0, 9'd16, 9'd511, 9'd0, 9'd300};
		phase_bytes[6] = BYTES_W'($urandom_range(65535, 1));
		phase_count[6] = COUNT_W'($urandom_range(64, 2));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default pool: pops, double free, misaligned free, range edges
		issue(OP_ALLOC, '0);
		issue(OP_ALLOC, FREE_BYTES_MAX);
		issue(OP_FREE, '0);
		issue(OP_FREE, '0);
		issue(OP_FREE, 24'd127);
		issue(OP_FREE, FREE_BYTES_MAX);
		issue(OP_FREE, 24'd16384);
		issue(OP_FREE, 24'd16383);
		issue(OP_ALLOC, '0);

		// Zero block size, two blocks: empty pool and insertion ahead of the head
		set_pool(16'd0, 9'd2);
		issue(OP_ALLOC, '0);
		issue(OP_ALLOC, '0);
		issue(OP_ALLOC, '0);
		issue(OP_FREE, 24'd1);
		issue(OP_FREE, 24'd0);
		issue(OP_FREE, 24'd1);
		issue(OP_FREE, 24'd2);
		issue(OP_ALLOC, '0);
		issue(OP_ALLOC, '0);
		issue(OP_FREE, 24'd0);

		// Zero block count, largest block size
		set_pool(16'hFFFF, 9'd0);
		issue(OP_ALLOC, '0);
		issue(OP_FREE, 24'd65534);
		issue(OP_FREE, 24'd65535);
		issue(OP_ALLOC, '0);
		issue(OP_ALLOC, '0);

		// Random phases, alternating fill and drain waves
		for (int p = 0; p < PHASES; p++) begin
			set_pool(phase_bytes[p], phase_count[p]);
			case (p % 3)
				0:       idle_mode = IDLE_NONE;
				1:       idle_mode = IDLE_HEAVY;
				default: idle_mode = IDLE_LIGHT;
			endcase
			for (int k = 0; k < PHASE_REQUESTS; k++) begin
				if (k % 40 == 0)
					wave_pct = ((k / 40) % 2 == 0) ? $urandom_range(90, 65) : $urandom_range(40, 15);
				if (p == 2 && k == PHASE_REQUESTS / 2) drain();
				random_request(wave_pct);
			end
		end

		drain();
		repeat (30) @(posedge clk);
		$display("Checked %0d replies over %0d register writes and several idle patterns;",
			replies_checked, config_writes);
		$display("  %0d empty-pool, %0d out-of-range and %0d double-free replies among them.",
			empty_hits, range_hits, dup_hits);
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sflpa_pkg.sv
rtl/sflpa_regs.sv
rtl/sflpa_div.sv
rtl/sflpa_dp.sv
rtl/sflpa_ctrl.sv
rtl/sorted_free_list_pool_allocator.sv
tb/sflpa_tb_pkg.sv
tb/sflpa_checker.sv
tb/sorted_free_list_pool_allocator_tb.sv
